// ----- src/hashed_lru_cache_with_fill_budget_macros.svh -----
// ----------------------------------------------------------------------------
// hashed lru cache assertion macros
// shared property forms for the cache checker, clocked on aclk
// ----------------------------------------------------------------------------
`ifndef HASHED_LRU_CACHE_WITH_FILL_BUDGET_MACROS_SVH
`define HASHED_LRU_CACHE_WITH_FILL_BUDGET_MACROS_SVH

// same-cycle implication, off during reset
`define HLC_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define HLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked through reset
`define HLC_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/hlc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlc_pkg
// shared constants and codes of the hashed lru cache
// ----------------------------------------------------------------------------
package hlc_pkg;

    localparam int ENTRIES_DEF  = 256;
    localparam int KEY_BITS_DEF = 64;
    localparam int STAMP_W      = 48;
    localparam int SLOT_W       = 8;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [7:0]         FPF_RESET   = 8'd2;
    localparam logic [STAMP_W-1:0] CLOCK_RESET = 48'd1;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_FRAME  = 1'b1;

    typedef enum logic [2:0] {
        ST_HIT   = 3'd0,
        ST_FILL  = 3'd1,
        ST_EVICT = 3'd2,
        ST_OVER  = 3'd3,
        ST_FRAME = 3'd4
    } status_t;

endpackage

// ----- src/hlc_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlc_mem
// directory ram, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module hlc_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 113
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/hlc_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlc_hash
// fnv-1a over eight key bytes, one byte per cycle, then the home index
// reduced modulo the table size, one hash byte per cycle
// ----------------------------------------------------------------------------
module hlc_hash
    import hlc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [63:0]                key,
    output logic                       done,
    output logic [$clog2(ENTRIES)-1:0] index
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int REM_W = IDX_W + 8;
    localparam logic [REM_W-1:0] ENT_R = REM_W'(ENTRIES);

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_FNV  = 3'b010,
        H_MOD  = 3'b100
    } hst_t;

    hst_t              st_reg, st_next;
    logic [2:0]        step_reg, step_next;
    logic [63:0]       data_reg, data_next;
    logic [31:0]       h_reg, h_next;
    logic [IDX_W-1:0]  rem_reg, rem_next;
    logic              done_reg, done_next;
    logic [31:0]       h_mix;
    logic [31:0]       prod;
    logic [REM_W-1:0]  t;

    assign h_mix = h_reg ^ {24'd0, data_reg[7:0]};
    assign prod  = h_mix * FNV_PRIME;

    // (rem * 256 + byte) mod ENTRIES by eight compare-subtract steps
    always_comb begin
        t = {rem_reg, h_reg[31:24]};
        for (int j = 7; j >= 0; j--) begin
            if (t >= (ENT_R << j)) begin
                t = t - (ENT_R << j);
            end
        end
    end

    always_comb begin
        st_next   = st_reg;
        step_next = step_reg;
        data_next = data_reg;
        h_next    = h_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        unique case (st_reg)
            H_IDLE: begin
                if (start) begin
                    data_next = key;
                    h_next    = FNV_BASIS;
                    step_next = 3'd0;
                    st_next   = H_FNV;
                end
            end
            H_FNV: begin
                h_next    = prod;
                data_next = data_reg >> 8;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7) begin
                    rem_next  = '0;
                    step_next = 3'd0;
                    st_next   = H_MOD;
                end
            end
            H_MOD: begin
                rem_next  = t[IDX_W-1:0];
                h_next    = h_reg << 8;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3) begin
                    done_next = 1'b1;
                    st_next   = H_IDLE;
                end
            end
            default: begin
                st_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= H_IDLE;
            done_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        data_reg <= data_next;
        h_reg    <= h_next;
        rem_reg  <= rem_next;
    end

    assign done  = done_reg;
    assign index = rem_reg;

endmodule

// ----- src/hashed_lru_cache_with_fill_budget.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_lru_cache_with_fill_budget
// lookup: hash over the key bytes, index reduction, handoff, probes, a directory
//   write, then the result; an lru eviction adds a scan of every entry, an
//   over-budget miss skips the write
// one item at a time: the next is taken in the same cycle as the result is raised,
//   as items are taken only in the idle state
// reset: a clearing pass over every entry empties the directory before the
//   first item is taken; config writes are taken throughout
// ----------------------------------------------------------------------------
module hashed_lru_cache_with_fill_budget
    import hlc_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [63:0]       s_key,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [2:0]        m_status,
    output logic [SLOT_W-1:0] m_slot
);

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int WORD_W = 1 + KEY_BITS + STAMP_W;
    localparam logic [IDX_W-1:0] ADDR_LAST = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(ENTRIES);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_PROBE = 7'b0001000,
        S_SCAN  = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     clr_reg, clr_next;
    logic [7:0]           fpf_reg, fpf_next;
    logic [7:0]           fills_reg, fills_next;
    logic [STAMP_W-1:0]   clock_reg, clock_next;
    logic [KEY_BITS-1:0]  key_reg, key_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic [CNT_W-1:0]     iss_reg, iss_next;
    logic [CNT_W-1:0]     chk_reg, chk_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_addr_reg, pend_addr_next;
    logic [IDX_W-1:0]     min_idx_reg, min_idx_next;
    logic [STAMP_W-1:0]   min_stamp_reg, min_stamp_next;
    status_t              res_status_reg, res_status_next;
    logic [IDX_W-1:0]     res_idx_reg, res_idx_next;
    logic                 m_valid_reg, m_valid_next;
    logic [2:0]           m_status_reg, m_status_next;
    logic [SLOT_W-1:0]    m_slot_reg, m_slot_next;

    logic                 hash_start;
    logic                 hash_done;
    logic [IDX_W-1:0]     hash_idx;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;
    logic                 issue;
    logic [WORD_W-1:0]    q;
    logic                 q_valid;
    logic [KEY_BITS-1:0]  q_key;
    logic [STAMP_W-1:0]   q_stamp;
    logic [IDX_W-1:0]     addr_inc;
    logic                 take_min;
    logic [IDX_W-1:0]     cand_idx;
    logic                 miss;
    logic                 miss_free;

    assign q_valid = q[WORD_W-1];
    assign q_key   = q[WORD_W-2 -: KEY_BITS];
    assign q_stamp = q[STAMP_W-1:0];

    assign addr_inc = (addr_reg == ADDR_LAST) ? '0 : addr_reg + 1'b1;
    assign issue    = (state_reg == S_PROBE || state_reg == S_SCAN) && (iss_reg != CNT_FULL);
    assign take_min = (chk_reg == '0) || (q_stamp < min_stamp_reg);
    assign cand_idx = take_min ? pend_addr_reg : min_idx_reg;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    hlc_hash #(
        .ENTRIES (ENTRIES)
    ) u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .key     (64'(s_key[KEY_BITS-1:0])),
        .done    (hash_done),
        .index   (hash_idx)
    );

    hlc_mem #(
        .DEPTH (ENTRIES),
        .WIDTH (WORD_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (issue),
        .raddr (addr_reg),
        .rdata (q)
    );

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        fpf_next        = fpf_reg;
        fills_next      = fills_reg;
        clock_next      = clock_reg;
        key_next        = key_reg;
        addr_next       = addr_reg;
        iss_next        = iss_reg;
        chk_next        = chk_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        min_idx_next    = min_idx_reg;
        min_stamp_next  = min_stamp_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        hash_start      = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = res_idx_reg;
        mem_wdata       = {1'b1, key_reg, clock_reg + 1'b1};
        miss            = 1'b0;
        miss_free       = 1'b0;

        if (cfg_valid) begin
            fpf_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // probe and scan reads go out back to back, data returns in the following cycle
        if (issue) begin
            addr_next      = addr_inc;
            iss_next       = iss_reg + 1'b1;
            pend_addr_next = addr_reg;
        end
        pend_next = issue;

        unique case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == REQ_FRAME) begin
                        fills_next      = '0;
                        res_status_next = ST_FRAME;
                        res_idx_next    = '0;
                        state_next      = S_DONE;
                    end else begin
                        key_next   = s_key[KEY_BITS-1:0];
                        hash_start = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    addr_next  = hash_idx;
                    iss_next   = '0;
                    chk_next   = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                if (pend_reg) begin
                    if (!q_valid) begin
                        miss      = 1'b1;
                        miss_free = 1'b1;
                    end else if (q_key == key_reg) begin
                        res_status_next = ST_HIT;
                        res_idx_next    = pend_addr_reg;
                        state_next      = S_WRITE;
                    end else begin
                        chk_next = chk_reg + 1'b1;
                        if (chk_reg == CNT_LAST) begin
                            miss = 1'b1;
                        end
                    end
                end
                if (miss) begin
                    if (fills_reg >= fpf_reg) begin
                        res_status_next = ST_OVER;
                        res_idx_next    = '0;
                        state_next      = S_DONE;
                    end else begin
                        fills_next = fills_reg + 8'd1;
                        if (miss_free) begin
                            res_status_next = ST_FILL;
                            res_idx_next    = pend_addr_reg;
                            state_next      = S_WRITE;
                        end else begin
                            // table full: sweep all stamps from entry 0
                            addr_next  = '0;
                            iss_next   = '0;
                            chk_next   = '0;
                            pend_next  = 1'b0;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (pend_reg) begin
                    // strict less-than keeps the lowest index on ties
                    if (take_min) begin
                        min_stamp_next = q_stamp;
                        min_idx_next   = pend_addr_reg;
                    end
                    chk_next = chk_reg + 1'b1;
                    if (chk_reg == CNT_LAST) begin
                        res_status_next = ST_EVICT;
                        res_idx_next    = cand_idx;
                        state_next      = S_WRITE;
                    end
                end
            end
            S_WRITE: begin
                mem_we     = 1'b1;
                clock_next = clock_reg + 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = SLOT_W'(res_idx_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            fpf_reg     <= FPF_RESET;
            fills_reg   <= '0;
            clock_reg   <= CLOCK_RESET;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            fpf_reg     <= fpf_next;
            fills_reg   <= fills_next;
            clock_reg   <= clock_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        key_reg        <= key_next;
        addr_reg       <= addr_next;
        iss_reg        <= iss_next;
        chk_reg        <= chk_next;
        pend_addr_reg  <= pend_addr_next;
        min_idx_reg    <= min_idx_next;
        min_stamp_reg  <= min_stamp_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;

endmodule

// ----- src/hlc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlc_checker
// port-level checks of the hashed lru cache, bound to the top level
// ----------------------------------------------------------------------------
`include "hashed_lru_cache_with_fill_budget_macros.svh"

module hlc_checker
    import hlc_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [2:0]        m_status,
    input logic [SLOT_W-1:0] m_slot
);

    `HLC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_slot), "result item changed while stalled")

    // over budget and frame items carry no slot
    `HLC_ASSERT(a_slot_zero, m_valid && (m_status == ST_OVER || m_status == ST_FRAME), m_slot == '0, "slot not zero for over budget or frame")

    // one item in flight at a time
    `HLC_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "item taken while another is at work")

    // clearing pass follows reset
    `HLC_ASSERT_NEXT_RST(a_clear_pass, !aresetn, !s_ready, "item taken before directory cleared")

endmodule

bind hashed_lru_cache_with_fill_budget hlc_checker u_hlc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_status (m_status),
    .m_slot   (m_slot)
);
